@@ hw/rtl/bouncing_box_pattern_generator_assert.svh @@
// Assertion macros for the bouncing box pattern generator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BOUNCING_BOX_PATTERN_GENERATOR_ASSERT_SVH
`define BOUNCING_BOX_PATTERN_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define BBPG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbpg: same-cycle check failed");
// Next-cycle implication
`define BBPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbpg: next-cycle check failed");
`else
`define BBPG_ASSERT_SAME(lbl, ante, cons)
`define BBPG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/bbpg_pkg.sv @@
// Shared types, constants and helper functions of the bouncing box generator.
// No dependencies; every other file but the assertion header imports this package.
package bbpg_pkg;

    // Sizes
    localparam int MAX_BOXES_DEFAULT = 8;
    localparam int BOX_INDEX_W       = 7;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 12;
    localparam int COORD_W           = 12;
    localparam int CENTRE_W          = 14;
    localparam int STEP_W            = 9;
    localparam int HALF_W            = 10;
    localparam int SIDE_W            = 11;
    localparam int SPEED_W           = 8;
    localparam int COUNT_W           = 4;
    localparam int BOXSEL_W          = 3;
    localparam int CHAN_W            = 8;

    // Register reset values
    localparam logic [COORD_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam logic [COUNT_W-1:0] ACTIVE_BOXES_RESET = 4'd3;
    localparam logic [SPEED_W-1:0] MOVE_SPEED_RESET   = 8'd1;
    localparam logic [SIDE_W-1:0]  BOX_SIDE_RESET     = 11'd200;

    // Colour levels
    localparam logic [CHAN_W-1:0] LEVEL_FULL = 8'd255;
    localparam logic [CHAN_W-1:0] LEVEL_HALF = 8'd128;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_ACTIVE_BOXES = 3'd2,
        REG_MOVE_SPEED   = 3'd3,
        REG_BOX_SIDE     = 3'd4
    } cfg_reg_t;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [2:0] {
        CLR_WHITE = 3'd0,
        CLR_RED   = 3'd1,
        CLR_GREEN = 3'd2,
        CLR_BLUE  = 3'd3,
        CLR_GREY  = 3'd4
    } colour_t;

    // Settings seen by every cell, already made effective
    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [HALF_W-1:0]  half;
        logic [SPEED_W-1:0] speed;
        logic [COUNT_W-1:0] active;
    } cfg_t;

    // Item travelling down the chain of cells
    typedef struct packed {
        logic                       is_pixel;
        logic [BOXSEL_W-1:0]        box_index;
        logic signed [CENTRE_W-1:0] load_x;
        logic signed [CENTRE_W-1:0] load_y;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic                       line_end;
        logic                       frame_end;
        colour_t                    colour;
    } tok_t;

    // Clamp a requested centre to [half, size - half]; half wins
    function automatic logic signed [CENTRE_W-1:0] clamp_start(
        input logic [COORD_W-1:0] req,
        input logic [COORD_W-1:0] size,
        input logic [HALF_W-1:0]  half
    );
        logic signed [CENTRE_W:0] v;
        logic signed [CENTRE_W:0] lim;
        logic signed [CENTRE_W:0] half_s;
        v      = signed'({3'b000, req});
        half_s = signed'({5'b00000, half});
        lim    = signed'({3'b000, size}) - half_s;
        if (v > lim) v = lim;
        if (v < half_s) v = half_s;
        return v[CENTRE_W-1:0];
    endfunction

    // Turn the step round at the frame edges; the low edge wins
    function automatic logic signed [STEP_W-1:0] bounce_step(
        input logic signed [CENTRE_W-1:0] c,
        input logic signed [STEP_W-1:0]   step,
        input logic [COORD_W-1:0]         size,
        input logic [HALF_W-1:0]          half,
        input logic [SPEED_W-1:0]         speed
    );
        logic signed [CENTRE_W:0] c_s;
        logic signed [CENTRE_W:0] half_s;
        logic signed [CENTRE_W:0] lim;
        logic signed [STEP_W-1:0] spd;
        logic signed [STEP_W-1:0] res;
        c_s    = signed'({c[CENTRE_W-1], c});
        half_s = signed'({5'b00000, half});
        lim    = signed'({3'b000, size}) - half_s;
        spd    = signed'({1'b0, speed});
        res    = step;
        if (c_s >= lim) res = -spd;
        if (c_s <= half_s) res = spd;
        return res;
    endfunction

    function automatic colour_t box_colour(input int unsigned idx);
        colour_t c;
        if (idx == 0) c = CLR_RED;
        else if (idx == 1) c = CLR_GREEN;
        else if (idx == 2) c = CLR_BLUE;
        else c = CLR_GREY;
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] colour_red(input colour_t c);
        logic [CHAN_W-1:0] v;
        unique case (c)
            CLR_WHITE, CLR_RED: v = LEVEL_FULL;
            CLR_GREEN, CLR_BLUE, CLR_GREY: v = LEVEL_HALF;
            default: v = LEVEL_FULL;
        endcase
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] colour_green(input colour_t c);
        logic [CHAN_W-1:0] v;
        unique case (c)
            CLR_WHITE, CLR_GREEN: v = LEVEL_FULL;
            CLR_RED, CLR_BLUE, CLR_GREY: v = LEVEL_HALF;
            default: v = LEVEL_FULL;
        endcase
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] colour_blue(input colour_t c);
        logic [CHAN_W-1:0] v;
        unique case (c)
            CLR_WHITE, CLR_BLUE: v = LEVEL_FULL;
            CLR_RED, CLR_GREEN, CLR_GREY: v = LEVEL_HALF;
            default: v = LEVEL_FULL;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/bbpg_stream_if.sv @@
// Valid/ready channel interfaces for the command input and the pixel output.
// Depends on bbpg_pkg for field widths.
interface bbpg_in_if;
    import bbpg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [BOXSEL_W-1:0]      box_index;
    logic [COORD_W-1:0]       start_x;
    logic [COORD_W-1:0]       start_y;

    modport source (output valid, command, box_index, start_x, start_y, input ready);
    modport sink   (input valid, command, box_index, start_x, start_y, output ready);
endinterface

interface bbpg_out_if;
    import bbpg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              line_end;
    logic              frame_end;

    modport source (output valid, red, green, blue, alpha, line_end, frame_end, input ready);
    modport sink   (input valid, red, green, blue, alpha, line_end, frame_end, output ready);
endinterface

@@ hw/rtl/bbpg_cell.sv @@
// One box of the generator: holds its centre and step, takes its load, paints passing
// pixels and moves at frame end. Depends on bbpg_pkg.
module bbpg_cell #(
    parameter int BOX_INDEX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bbpg_pkg::cfg_t cfg,
    input  logic           advance,
    input  logic           prior_valid,
    input  bbpg_pkg::tok_t prior_tok,
    output logic           valid,
    output bbpg_pkg::tok_t tok
);
    import bbpg_pkg::*;

    localparam logic [BOX_INDEX_W-1:0] IndexCode  = BOX_INDEX_W'(BOX_INDEX);
    localparam colour_t                CellColour = box_colour(BOX_INDEX);

    logic signed [CENTRE_W-1:0] cx_reg, cx_next;
    logic signed [CENTRE_W-1:0] cy_reg, cy_next;
    logic signed [STEP_W-1:0]   sx_reg, sx_next;
    logic signed [STEP_W-1:0]   sy_reg, sy_next;
    logic                       valid_reg;
    tok_t                       tok_reg, tok_next;

    logic                       cell_active;
    logic                       take;
    logic                       hit;
    logic signed [CENTRE_W:0]   col_s, row_s, cx_s, cy_s, half_s;
    logic signed [STEP_W-1:0]   sx_new, sy_new;

    assign cell_active = {3'b000, cfg.active} > IndexCode;
    assign take        = advance && prior_valid;

    // Test the pixel against this box's square, clipped to the frame
    always_comb
    begin
        col_s  = signed'({3'b000, prior_tok.col});
        row_s  = signed'({3'b000, prior_tok.row});
        cx_s   = signed'({cx_reg[CENTRE_W-1], cx_reg});
        cy_s   = signed'({cy_reg[CENTRE_W-1], cy_reg});
        half_s = signed'({5'b00000, cfg.half});
        hit    = (col_s >= cx_s - half_s) && (col_s < cx_s + half_s) &&
                 (prior_tok.col < cfg.width) &&
                 (row_s >= cy_s - half_s) && (row_s < cy_s + half_s) &&
                 (prior_tok.row < cfg.height);
    end

    // Paint the pixel and hand the item on
    always_comb
    begin
        tok_next = prior_tok;
        if (prior_tok.is_pixel == CMD_PIXEL && cell_active && hit)
        begin
            tok_next.colour = CellColour;
        end
    end

    // Load, or bounce and move at frame end
    always_comb
    begin
        sx_new  = bounce_step(cx_reg, sx_reg, cfg.width, cfg.half, cfg.speed);
        sy_new  = bounce_step(cy_reg, sy_reg, cfg.height, cfg.half, cfg.speed);
        cx_next = cx_reg;
        cy_next = cy_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        if (take && prior_tok.is_pixel == CMD_LOAD &&
            {4'b0000, prior_tok.box_index} == IndexCode)
        begin
            cx_next = prior_tok.load_x;
            cy_next = prior_tok.load_y;
            sx_next = STEP_W'(1);
            sy_next = STEP_W'(1);
        end
        else if (take && prior_tok.is_pixel == CMD_PIXEL && prior_tok.frame_end &&
                 cell_active)
        begin
            sx_next = sx_new;
            sy_next = sy_new;
            cx_next = cx_reg + {{(CENTRE_W-STEP_W){sx_new[STEP_W-1]}}, sx_new};
            cy_next = cy_reg + {{(CENTRE_W-STEP_W){sy_new[STEP_W-1]}}, sy_new};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            sx_reg    <= STEP_W'(1);
            sy_reg    <= STEP_W'(1);
            valid_reg <= 1'b0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            if (advance)
            begin
                valid_reg <= prior_valid;
            end
        end
    end

    // Payload holds while the chain is stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign valid = valid_reg;
    assign tok   = tok_reg;

endmodule

@@ hw/rtl/bbpg_front.sv @@
// Entry of the chain: raster counters and load clamping, forming the item
// handed to the first cell. Depends on bbpg_pkg.
module bbpg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbpg_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic                          command,
    input  logic [bbpg_pkg::BOXSEL_W-1:0] box_index,
    input  logic [bbpg_pkg::COORD_W-1:0]  start_x,
    input  logic [bbpg_pkg::COORD_W-1:0]  start_y,
    output bbpg_pkg::tok_t                tok
);
    import bbpg_pkg::*;

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               line_end;
    logic               frame_end;

    assign line_end  = col_reg >= cfg.width - COORD_W'(1);
    assign frame_end = line_end && (row_reg >= cfg.height - COORD_W'(1));

    // Advance the raster on each pixel transfer
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && command == CMD_PIXEL)
        begin
            if (line_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Build the item for the first cell
    always_comb
    begin
        tok.is_pixel  = command;
        tok.box_index = box_index;
        tok.load_x    = clamp_start(start_x, cfg.width, cfg.half);
        tok.load_y    = clamp_start(start_y, cfg.height, cfg.half);
        tok.col       = col_reg;
        tok.row       = row_reg;
        tok.line_end  = line_end;
        tok.frame_end = frame_end;
        tok.colour    = CLR_WHITE;
    end

endmodule

@@ hw/rtl/bouncing_box_pattern_generator.sv @@
// A transfer in passes the MAX_BOXES cell registers on its way to the output.
// Throughput: one item per cycle through a chain of MAX_BOXES cells, one per
// box; the last cell is the output register and a stall freezes the chain.
// Reset: registers take their defaults, boxes sit at 0,0 with step +1,
// raster at the origin; no clearing pass.
`include "bouncing_box_pattern_generator_assert.svh"

module bouncing_box_pattern_generator #(
    parameter int MAX_BOXES = bbpg_pkg::MAX_BOXES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bbpg_in_if.sink                          cmd_ch,
    bbpg_out_if.source                       pix_ch,
    input  logic                             cfg_we,
    input  logic [bbpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbpg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bbpg_pkg::*;

    logic [COORD_W-1:0] frame_width_reg;
    logic [COORD_W-1:0] frame_height_reg;
    logic [COUNT_W-1:0] active_boxes_reg;
    logic [SPEED_W-1:0] move_speed_reg;
    logic [SIDE_W-1:0]  box_side_reg;

    cfg_t cfg;
    logic advance;
    logic accept;
    logic out_valid;
    logic pixel_at_line_end;
    tok_t tok_chain   [MAX_BOXES+1];
    logic valid_chain [MAX_BOXES+1];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            active_boxes_reg <= ACTIVE_BOXES_RESET;
            move_speed_reg   <= MOVE_SPEED_RESET;
            box_side_reg     <= BOX_SIDE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[COORD_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[COORD_W-1:0];
                REG_ACTIVE_BOXES: active_boxes_reg <= cfg_wdata[COUNT_W-1:0];
                REG_MOVE_SPEED:   move_speed_reg   <= cfg_wdata[SPEED_W-1:0];
                REG_BOX_SIDE:     box_side_reg     <= cfg_wdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective settings: a zero frame size acts as one
    always_comb
    begin
        cfg.width  = (frame_width_reg == '0) ? COORD_W'(1) : frame_width_reg;
        cfg.height = (frame_height_reg == '0) ? COORD_W'(1) : frame_height_reg;
        cfg.half   = box_side_reg[SIDE_W-1:1];
        cfg.speed  = move_speed_reg;
        cfg.active = active_boxes_reg;
    end

    // Move the whole chain unless a finished pixel waits
    assign out_valid    = valid_chain[MAX_BOXES] && tok_chain[MAX_BOXES].is_pixel == CMD_PIXEL;
    assign advance      = !out_valid || pix_ch.ready;
    assign accept       = cmd_ch.valid && advance;
    assign cmd_ch.ready = advance;

    bbpg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .command   (cmd_ch.command),
        .box_index (cmd_ch.box_index),
        .start_x   (cmd_ch.start_x),
        .start_y   (cmd_ch.start_y),
        .tok       (tok_chain[0])
    );
    assign valid_chain[0] = cmd_ch.valid;

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        bbpg_cell #(
            .BOX_INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg         (cfg),
            .advance     (advance),
            .prior_valid (valid_chain[i]),
            .prior_tok   (tok_chain[i]),
            .valid       (valid_chain[i+1]),
            .tok         (tok_chain[i+1])
        );
    end

    // Drive the output from the last cell; loads drop out here
    assign pix_ch.valid     = out_valid;
    assign pix_ch.red       = colour_red(tok_chain[MAX_BOXES].colour);
    assign pix_ch.green     = colour_green(tok_chain[MAX_BOXES].colour);
    assign pix_ch.blue      = colour_blue(tok_chain[MAX_BOXES].colour);
    assign pix_ch.alpha     = LEVEL_FULL;
    assign pix_ch.line_end  = tok_chain[MAX_BOXES].line_end;
    assign pix_ch.frame_end = tok_chain[MAX_BOXES].frame_end;

    // Checks
    assign pixel_at_line_end = accept && cmd_ch.command == CMD_PIXEL && tok_chain[0].line_end;

    `BBPG_ASSERT_SAME(a_frame_end_ends_line, pix_ch.valid && pix_ch.frame_end, pix_ch.line_end)
    `BBPG_ASSERT_SAME(a_stall_only_on_pixel, !cmd_ch.ready, pix_ch.valid && !pix_ch.ready)
    `BBPG_ASSERT_NEXT(a_line_wraps, pixel_at_line_end, tok_chain[0].col == '0)

endmodule
